### rtl/core/ray_triangle_intersect_defines.svh
// Assertion macros for the ray_triangle_intersect RTL, used by rti_fifo.
`ifndef RAY_TRIANGLE_INTERSECT_DEFINES_SVH
`define RAY_TRIANGLE_INTERSECT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RTI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/rti_pkg.sv
`default_nettype none
package rti_pkg;

  // Tolerance register
  localparam int TOL_W = 16;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  // Configuration register indexes
  localparam int CFG_AW = 3;
  typedef enum logic [CFG_AW-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_DIR_X    = 3'd3,
    REG_DIR_Y    = 3'd4,
    REG_DIR_Z    = 3'd5,
    REG_TOL      = 3'd6
  } cfg_reg_t;

  // Multiplier slice: unsigned low chunks, signed top chunk, 32x32 products
  localparam int MUL_CHUNK = 31;

  // Queue between classifier and back end
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW = 1;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

### rtl/core/rti_mul.sv
`default_nettype none
// Pipelined signed multiplier built from 32x32 partial products.
// Registered stages: partial products, row sums, final sum.
module rti_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic                 clk,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);
  import rti_pkg::*;

  localparam int K   = MUL_CHUNK;
  localparam int NA  = (AW + K - 1) / K;
  localparam int NB  = (BW + K - 1) / K;
  localparam int AXW = NA * K;
  localparam int BXW = NB * K;
  localparam int PW  = AW + BW;

  logic signed [AXW-1:0] ax;
  logic signed [BXW-1:0] bx;
  logic signed [K:0]     ca [NA];
  logic signed [K:0]     cb [NB];
  logic signed [2*K+1:0] pp [NA][NB];
  logic signed [PW-1:0]  row_c [NA];
  logic signed [PW-1:0]  row [NA];
  logic signed [PW-1:0]  tot_c;

  assign ax = AXW'(a);
  assign bx = BXW'(b);

  // split into chunks, top chunk carries the sign
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) ca[i] = {ax[AXW-1], ax[i*K +: K]};
      else ca[i] = {1'b0, ax[i*K +: K]};
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) cb[j] = {bx[BXW-1], bx[j*K +: K]};
      else cb[j] = {1'b0, bx[j*K +: K]};
    end
  end

  // stage 1: partial products
  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp[i][j] <= ca[i] * cb[j];
      end
    end
  end

  // stage 2: sum each row
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_c[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_c[i] = row_c[i] + (PW'(pp[i][j]) << (K * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NA; i++) row[i] <= row_c[i];
  end

  // stage 3: sum the rows
  always_comb begin
    tot_c = '0;
    for (int i = 0; i < NA; i++) tot_c = tot_c + (row[i] << (K * i));
  end

  always_ff @(posedge clk) begin
    p <= tot_c;
  end

endmodule
`default_nettype wire

### rtl/core/rti_front.sv
`default_nettype none
// Front end: edges, cross products, determinant and barycentric terms,
// then hit classification. Fixed 13-stage pipeline, one item per cycle.
module rti_front #(
  parameter int W  = 32,
  parameter int F  = 16,
  parameter int DW = 3 * W + 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic signed [W-1:0]         a [3],
  input  logic signed [W-1:0]         b [3],
  input  logic signed [W-1:0]         c [3],
  input  logic                        mesh_end,
  input  logic signed [W-1:0]         org [3],
  input  logic signed [W-1:0]         dir [3],
  input  logic [rti_pkg::TOL_W-1:0]   tol,
  output logic                        push,
  output logic [2*DW+1:0]             push_data
);
  import rti_pkg::*;

  localparam int EW  = W + 1;
  localparam int PW  = 2 * W + 2;
  localparam int QW  = 2 * W + 3;
  localparam int DW1 = DW + 1;
  localparam int EDW = DW + TOL_W + 1;
  localparam int XW  = DW + F + TOL_W + 1;
  localparam int LF  = 13;

  logic [LF:1] vld;
  logic [LF:1] mend;

  logic signed [EW-1:0] e1_s [1:5][3];
  logic signed [EW-1:0] e2_s [1:5][3];
  logic signed [EW-1:0] s_s  [1:5][3];

  logic signed [2*W:0]    pa [3];
  logic signed [2*W:0]    pb [3];
  logic signed [2*EW-1:0] qa [3];
  logic signed [2*EW-1:0] qb [3];
  logic signed [PW-1:0]   p_5 [3];
  logic signed [QW-1:0]   q_5 [3];

  logic signed [EW+PW-1:0] md [3];
  logic signed [EW+PW-1:0] mu [3];
  logic signed [W+QW-1:0]  mv [3];
  logic signed [EW+QW-1:0] mt [3];

  logic signed [DW-1:0] det9, u9, v9, t9;
  logic                 neg9;
  logic [DW-1:0]        absdet;

  logic signed [DW-1:0] detn_d [10:13];
  logic signed [DW-1:0] tn_d [10:13];
  logic signed [DW-1:0] un10, vn10;
  logic                 flat_d [10:13];
  logic                 rng_d [11:13];
  logic signed [EDW-1:0] epsdet;
  logic                 hit_c;

  // valid and mesh marker travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LF-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    mend <= {mend[LF-1:1], mesh_end};
  end

  // stage 1: edges and origin offset, delayed to stage 5
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      e1_s[1][i] <= EW'(b[i]) - EW'(a[i]);
      e2_s[1][i] <= EW'(c[i]) - EW'(a[i]);
      s_s[1][i]  <= EW'(org[i]) - EW'(a[i]);
      for (int st = 2; st <= 5; st++) begin
        e1_s[st][i] <= e1_s[st-1][i];
        e2_s[st][i] <= e2_s[st-1][i];
        s_s[st][i]  <= s_s[st-1][i];
      end
    end
  end

  // stages 2-5: p = dir x e2, q = s x e1
  for (genvar i = 0; i < 3; i++) begin : g_cross
    rti_mul #(.AW(W), .BW(EW)) u_pa (
      .clk, .a(dir[(i+1)%3]), .b(e2_s[1][(i+2)%3]), .p(pa[i]));
    rti_mul #(.AW(W), .BW(EW)) u_pb (
      .clk, .a(dir[(i+2)%3]), .b(e2_s[1][(i+1)%3]), .p(pb[i]));
    rti_mul #(.AW(EW), .BW(EW)) u_qa (
      .clk, .a(s_s[1][(i+1)%3]), .b(e1_s[1][(i+2)%3]), .p(qa[i]));
    rti_mul #(.AW(EW), .BW(EW)) u_qb (
      .clk, .a(s_s[1][(i+2)%3]), .b(e1_s[1][(i+1)%3]), .p(qb[i]));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p_5[i] <= PW'(pa[i]) - PW'(pb[i]);
      q_5[i] <= QW'(qa[i]) - QW'(qb[i]);
    end
  end

  // stages 6-9: det = e1.p, U = s.p, V = dir.q, T = e2.q
  for (genvar i = 0; i < 3; i++) begin : g_dot
    rti_mul #(.AW(EW), .BW(PW)) u_md (.clk, .a(e1_s[5][i]), .b(p_5[i]), .p(md[i]));
    rti_mul #(.AW(EW), .BW(PW)) u_mu (.clk, .a(s_s[5][i]), .b(p_5[i]), .p(mu[i]));
    rti_mul #(.AW(W), .BW(QW)) u_mv (.clk, .a(dir[i]), .b(q_5[i]), .p(mv[i]));
    rti_mul #(.AW(EW), .BW(QW)) u_mt (.clk, .a(e2_s[5][i]), .b(q_5[i]), .p(mt[i]));
  end

  always_ff @(posedge clk) begin
    det9 <= DW'(md[0]) + DW'(md[1]) + DW'(md[2]);
    u9   <= DW'(mu[0]) + DW'(mu[1]) + DW'(mu[2]);
    v9   <= DW'(mv[0]) + DW'(mv[1]) + DW'(mv[2]);
    t9   <= DW'(mt[0]) + DW'(mt[1]) + DW'(mt[2]);
  end

  // stage 10: flat test, fold sign of det into all terms
  assign neg9   = det9[DW-1];
  assign absdet = neg9 ? DW'(-det9) : DW'(det9);

  always_ff @(posedge clk) begin
    flat_d[10] <= !((DW1'(tol) << (2 * F)) < DW1'(absdet));
    detn_d[10] <= neg9 ? -det9 : det9;
    un10       <= neg9 ? -u9 : u9;
    vn10       <= neg9 ? -v9 : v9;
    tn_d[10]   <= neg9 ? -t9 : t9;
    // stage 11: barycentric range check
    rng_d[11] <= !(un10[DW-1] || (detn_d[10] < un10) || vn10[DW-1] ||
                   (DW1'(detn_d[10]) < (DW1'(un10) + DW1'(vn10))));
    for (int st = 11; st <= 13; st++) begin
      detn_d[st] <= detn_d[st-1];
      tn_d[st]   <= tn_d[st-1];
      flat_d[st] <= flat_d[st-1];
    end
    for (int st = 12; st <= 13; st++) rng_d[st] <= rng_d[st-1];
  end

  // stages 11-13: eps * det for the distance test
  rti_mul #(.AW(TOL_W + 1), .BW(DW)) u_ed (
    .clk, .a($signed({1'b0, tol})), .b(detn_d[10]), .p(epsdet));

  // stage 13: final decision
  assign hit_c = !flat_d[13] && rng_d[13] && (XW'(epsdet) < (XW'(tn_d[13]) <<< F));

  assign push      = vld[LF];
  assign push_data = {hit_c, mend[LF], detn_d[13], tn_d[13]};

endmodule
`default_nettype wire

### rtl/core/rti_fifo.sv
`default_nettype none
`include "ray_triangle_intersect_defines.svh"
// Short queue between classifier and back end.
module rti_fifo #(
  parameter int IW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [IW-1:0]       wdata,
  input  logic                pop,
  output logic [IW-1:0]       rdata,
  output rti_pkg::fifo_stat_t stat
);
  import rti_pkg::*;

  logic [IW-1:0]      mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp;
  logic [FIFO_AW:0]   cnt, cnt_next;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  assign rdata = mem[rp];

  // occupancy
  always_comb begin
    cnt_next = cnt;
    case ({push, pop})
      2'b10:   cnt_next = cnt + 1'b1;
      2'b01:   cnt_next = cnt - 1'b1;
      default: cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt_next;
    end
  end

  assign stat.full  = (cnt == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (cnt == '0);

  `RTI_ASSERT_IMP(a_no_overflow, clk, rst, push, !stat.full, "item pushed into full queue")
  `RTI_ASSERT_IMP(a_no_underflow, clk, rst, pop, !stat.empty, "item popped from empty queue")
  `RTI_ASSERT_NXT(a_cnt_up, clk, rst, push && !pop, cnt == $past(cnt) + 1'b1, "count did not rise")
  `RTI_ASSERT_NXT(a_cnt_dn, clk, rst, pop && !push, cnt == $past(cnt) - 1'b1, "count did not fall")

endmodule
`default_nettype wire

### rtl/core/rti_back.sv
`default_nettype none
// Back end: hit point = origin + dir * T / det, saturated.
// dir*T multiply, magnitude, then a pipelined restoring divider of
// COORD_WIDTH+1 quotient bits with an overflow stage, one bit per stage.
module rti_back #(
  parameter int W  = 32,
  parameter int DW = 3 * W + 6
) (
  input  logic                clk,
  input  logic                rst,
  input  rti_pkg::fifo_stat_t stat,
  input  logic [2*DW+1:0]     item,
  output logic                pop,
  input  logic signed [W-1:0] org [3],
  input  logic signed [W-1:0] dir [3],
  output logic                done,
  output logic                hit,
  output logic signed [W-1:0] point [3],
  output logic                final_res
);
  import rti_pkg::*;

  localparam int NQ = W + 1;
  localparam int RW = W + DW;
  localparam int CW = DW + NQ + 1;
  localparam int SW = W + 3;
  localparam int LB = 5 + NQ;
  localparam int LD = 4 + NQ;

  logic                 hit_0, me_0;
  logic [DW-1:0]        det_0;
  logic signed [DW-1:0] t_0;

  logic [LB:1]   vld, hsh, msh;
  logic [DW-1:0] det_sh [1:LD];

  assign pop   = !stat.empty;
  assign hit_0 = item[2*DW+1];
  assign me_0  = item[2*DW];
  assign det_0 = item[2*DW-1:DW];
  assign t_0   = $signed(item[DW-1:0]);

  // control and divisor travel with the item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LB-1:1], pop};
    end
  end

  always_ff @(posedge clk) begin
    hsh <= {hsh[LB-1:1], hit_0};
    msh <= {msh[LB-1:1], me_0};
    det_sh[1] <= det_0;
    for (int st = 2; st <= LD; st++) det_sh[st] <= det_sh[st-1];
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [RW-1:0] prod;
    logic [RW-1:0]        mag;
    logic                 ng4;
    logic [RW-1:0]        rem [0:NQ];
    logic [NQ-1:0]        qb [0:NQ];
    logic                 ovf [0:NQ];
    logic                 sgn [0:NQ];
    logic [NQ:0]          qf;
    logic signed [SW-1:0] quo, sum;
    logic signed [W-1:0]  sat;

    rti_mul #(.AW(W), .BW(DW)) u_mul (.clk, .a(dir[i]), .b(t_0), .p(prod));

    // magnitude, then overflow check against det << NQ
    always_ff @(posedge clk) begin
      mag    <= prod[RW-1] ? RW'(-prod) : RW'(prod);
      ng4    <= prod[RW-1];
      rem[0] <= mag;
      ovf[0] <= CW'(mag) >= (CW'(det_sh[4]) << NQ);
      qb[0]  <= '0;
      sgn[0] <= ng4;
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 1; k <= NQ; k++) begin : g_step
      logic [CW-1:0] dsh;
      logic          ge;

      assign dsh = CW'(det_sh[4+k]) << (NQ - k);
      assign ge  = CW'(rem[k-1]) >= dsh;

      always_ff @(posedge clk) begin
        rem[k] <= ge ? rem[k-1] - RW'(dsh) : rem[k-1];
        qb[k]  <= qb[k-1] | (NQ'(ge) << (NQ - k));
        ovf[k] <= ovf[k-1];
        sgn[k] <= sgn[k-1];
      end
    end

    // any quotient of 2^W or more saturates, so clamp there
    assign qf  = ovf[NQ] ? ((NQ+1)'(1) << W) : {1'b0, qb[NQ]};
    assign quo = sgn[NQ] ? -$signed(SW'(qf)) : $signed(SW'(qf));
    assign sum = SW'(org[i]) + quo;

    always_comb begin
      if ((&sum[SW-1:W-1]) || !(|sum[SW-1:W-1])) sat = sum[W-1:0];
      else if (sum[SW-1]) sat = {1'b1, {(W-1){1'b0}}};
      else sat = {1'b0, {(W-1){1'b1}}};
    end

    always_ff @(posedge clk) begin
      point[i] <= hsh[LB] ? sat : '0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LB];
    end
  end

  always_ff @(posedge clk) begin
    hit       <= hsh[LB];
    final_res <= msh[LB];
  end

endmodule
`default_nettype wire

### rtl/core/ray_triangle_intersect.sv
`default_nettype none
// Moller-Trumbore ray/triangle test in exact fixed point. Load the ray origin,
// direction and tolerance through the cfg port, then stream triangles: one is
// taken on every clock where start is high and busy is low, back to back with
// no gaps. Each triangle yields exactly one result, in order, on a one-cycle
// done strobe; the path runs through the classifier pipeline (13 stages, three
// multiplier passes), the queue, and the back end whose restoring divider takes
// one quotient bit per stage. The receiver cannot stall, so results must be
// captured on the cycle done is high. Misses report zero coordinates.
module ray_triangle_intersect #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cfg_we,
  input  logic [rti_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [COORD_WIDTH-1:0]         cfg_data,
  input  logic signed [COORD_WIDTH-1:0]  a_x,
  input  logic signed [COORD_WIDTH-1:0]  a_y,
  input  logic signed [COORD_WIDTH-1:0]  a_z,
  input  logic signed [COORD_WIDTH-1:0]  b_x,
  input  logic signed [COORD_WIDTH-1:0]  b_y,
  input  logic signed [COORD_WIDTH-1:0]  b_z,
  input  logic signed [COORD_WIDTH-1:0]  c_x,
  input  logic signed [COORD_WIDTH-1:0]  c_y,
  input  logic signed [COORD_WIDTH-1:0]  c_z,
  input  logic                           mesh_end,
  output logic                           done,
  output logic                           hit,
  output logic signed [COORD_WIDTH-1:0]  point_x,
  output logic signed [COORD_WIDTH-1:0]  point_y,
  output logic signed [COORD_WIDTH-1:0]  point_z,
  output logic                           final_res
);
  import rti_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = 3 * W + 6;
  localparam int QI_W = 2 * DW + 2;

  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];
  logic [TOL_W-1:0]    tol;

  logic signed [W-1:0] va [3], vb [3], vc [3];
  logic signed [W-1:0] pt [3];

  logic            accept;
  logic            push, pop;
  logic [QI_W-1:0] push_data, pop_data;
  fifo_stat_t      stat;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] <= '0;
        dir[i] <= '0;
      end
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_ORIGIN_X: org[0] <= cfg_data;
        REG_ORIGIN_Y: org[1] <= cfg_data;
        REG_ORIGIN_Z: org[2] <= cfg_data;
        REG_DIR_X:    dir[0] <= cfg_data;
        REG_DIR_Y:    dir[1] <= cfg_data;
        REG_DIR_Z:    dir[2] <= cfg_data;
        REG_TOL:      tol    <= cfg_data[TOL_W-1:0];
        default:      ;
      endcase
    end
  end

  assign va[0] = a_x;
  assign va[1] = a_y;
  assign va[2] = a_z;
  assign vb[0] = b_x;
  assign vb[1] = b_y;
  assign vb[2] = b_z;
  assign vc[0] = c_x;
  assign vc[1] = c_y;
  assign vc[2] = c_z;

  assign busy   = stat.full;
  assign accept = start && !busy;

  // classifier
  rti_front #(.W(W), .F(FRAC_BITS), .DW(DW)) u_front (
    .clk, .rst, .in_valid(accept), .a(va), .b(vb), .c(vc), .mesh_end,
    .org, .dir, .tol, .push, .push_data);

  // queue
  rti_fifo #(.IW(QI_W)) u_fifo (
    .clk, .rst, .push, .wdata(push_data), .pop, .rdata(pop_data), .stat);

  // hit point
  rti_back #(.W(W), .DW(DW)) u_back (
    .clk, .rst, .stat, .item(pop_data), .pop, .org, .dir,
    .done, .hit, .point(pt), .final_res);

  assign point_x = pt[0];
  assign point_y = pt[1];
  assign point_z = pt[2];

endmodule
`default_nettype wire

### test/tb_ray_triangle_intersect.sv
`timescale 1ns / 100ps
`default_nettype none
module tb_ray_triangle_intersect;
  import rti_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
  // no register sits at this index; writes there must be dropped
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] v [9];  // a_x..a_z, b_x..b_z, c_x..c_z
    logic                 last;
  } tri_t;

  typedef struct {
    logic                 hit;
    logic signed [CW-1:0] pt [3];
    logic                 last;
  } isect_t;

  // Scoreboard: mirrors the ray registers, predicts each intersection
  class isect_scoreboard;
    logic signed [CW-1:0] org [3];
    logic signed [CW-1:0] dir [3];
    logic [TOL_W-1:0]     tol;
    isect_t               pending [$];
    int                   errors;

    function new();
      foreach (org[i]) begin
        org[i] = '0;
        dir[i] = '0;
      end
      tol = TOL_RESET;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] idx, logic [CW-1:0] val);
      case (idx)
        REG_ORIGIN_X: org[0] = val;
        REG_ORIGIN_Y: org[1] = val;
        REG_ORIGIN_Z: org[2] = val;
        REG_DIR_X:    dir[0] = val;
        REG_DIR_Y:    dir[1] = val;
        REG_DIR_Z:    dir[2] = val;
        REG_TOL:      tol = val[TOL_W-1:0];
        default:      ;
      endcase
    endfunction

    // exact Moller-Trumbore with no division until the hit point
    function void note_triangle(tri_t t);
      wide_t e1 [3], e2 [3], s [3], p [3], q [3], d [3], o [3];
      wide_t det, uu, vv, tt, eps, quo, sum;
      isect_t r;
      logic ok;
      for (int i = 0; i < 3; i++) begin
        e1[i] = wide_t'(t.v[3+i]) - wide_t'(t.v[i]);
        e2[i] = wide_t'(t.v[6+i]) - wide_t'(t.v[i]);
        o[i]  = wide_t'(org[i]);
        d[i]  = wide_t'(dir[i]);
        s[i]  = o[i] - wide_t'(t.v[i]);
      end
      p[0] = d[1]*e2[2] - d[2]*e2[1];
      p[1] = d[2]*e2[0] - d[0]*e2[2];
      p[2] = d[0]*e2[1] - d[1]*e2[0];
      q[0] = s[1]*e1[2] - s[2]*e1[1];
      q[1] = s[2]*e1[0] - s[0]*e1[2];
      q[2] = s[0]*e1[1] - s[1]*e1[0];
      det = e1[0]*p[0] + e1[1]*p[1] + e1[2]*p[2];
      uu  = s[0]*p[0] + s[1]*p[1] + s[2]*p[2];
      vv  = d[0]*q[0] + d[1]*q[1] + d[2]*q[2];
      tt  = e2[0]*q[0] + e2[1]*q[1] + e2[2]*q[2];
      eps = wide_t'({1'b0, tol});
      ok = 1'b1;
      // flat or parallel
      if ((eps <<< (2*FB)) >= (det < 0 ? -det : det)) ok = 1'b0;
      if (ok && det < 0) begin
        det = -det; uu = -uu; vv = -vv; tt = -tt;
      end
      // outside the triangle
      if (ok && (uu < 0 || uu > det)) ok = 1'b0;
      if (ok && (vv < 0 || uu + vv > det)) ok = 1'b0;
      // too close or behind
      if (ok && eps * det >= (tt <<< FB)) ok = 1'b0;
      r.hit = ok;
      r.last = t.last;
      for (int i = 0; i < 3; i++) begin
        r.pt[i] = '0;
        if (ok) begin
          quo = (d[i] * tt) / det;  // truncates toward zero
          sum = o[i] + quo;
          if (sum > wide_t'(CMAX)) sum = wide_t'(CMAX);
          if (sum < wide_t'(CMIN)) sum = wide_t'(CMIN);
          r.pt[i] = sum[CW-1:0];
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(isect_t got);
      isect_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result hit=%0b pt=%h %h %h", $time, got.hit,
                 got.pt[0], got.pt[1], got.pt[2]);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.hit !== exp_r.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, exp_r.hit, got.hit);
        errors++;
      end
      for (int i = 0; i < 3; i++)
        if (got.pt[i] !== exp_r.pt[i]) begin
          $display("%0t: point[%0d] expected %h actual %h", $time, i, exp_r.pt[i],
                   got.pt[i]);
          errors++;
        end
      if (got.last !== exp_r.last) begin
        $display("%0t: final_res expected %0b actual %0b", $time, exp_r.last,
                 got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_data = '0;
  logic signed [CW-1:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [CW-1:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [CW-1:0] c_x = '0, c_y = '0, c_z = '0;
  logic mesh_end = 1'b0;
  logic done, hit, final_res;
  logic signed [CW-1:0] point_x, point_y, point_z;
  logic no_gaps = 1'b0;

  isect_scoreboard sb = new();

  ray_triangle_intersect dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z), .mesh_end(mesh_end),
    .done(done), .hit(hit), .point_x(point_x), .point_y(point_y),
    .point_z(point_z), .final_res(final_res)
  );

  always #5 clk = ~clk;

  // note each accepted triangle
  always @(posedge clk) begin
    tri_t t;
    if (!rst && start && !busy) begin
      t.v = '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
      t.last = mesh_end;
      sb.note_triangle(t);
    end
  end

  // results cannot be held off: check every strobe
  always @(posedge clk) begin
    isect_t r;
    if (!rst && done) begin
      r.hit = hit;
      r.pt = '{point_x, point_y, point_z};
      r.last = final_res;
      sb.check_result(r);
    end
  end

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
  endtask

  task automatic load_ray(logic signed [CW-1:0] o0, o1, o2, d0, d1, d2,
                          logic [CW-1:0] tol_word);
    write_reg(REG_ORIGIN_X, o0);
    write_reg(REG_ORIGIN_Y, o1);
    write_reg(REG_ORIGIN_Z, o2);
    write_reg(REG_DIR_X, d0);
    write_reg(REG_DIR_Y, d1);
    write_reg(REG_DIR_Z, d2);
    write_reg(REG_TOL, tol_word);
    write_reg(REG_UNUSED, $urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // start goes low before about one item in six
  task automatic send_tri(tri_t t);
    if (!no_gaps && $urandom_range(99) < 16) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {a_x, a_y, a_z} <= {t.v[0], t.v[1], t.v[2]};
    {b_x, b_y, b_z} <= {t.v[3], t.v[4], t.v[5]};
    {c_x, c_y, c_z} <= {t.v[6], t.v[7], t.v[8]};
    mesh_end <= t.last;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_coords(logic signed [CW-1:0] ax, ay, az, bx, by, bz,
                             cx, cy, cz, logic last);
    tri_t t;
    t.v = '{ax, ay, az, bx, by, bz, cx, cy, cz};
    t.last = last;
    send_tri(t);
  endtask

  // drain the pipe before touching the ray
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // mostly triangles straddling the ray, the rest raw noise
  task automatic random_mesh(int count);
    tri_t t;
    logic signed [63:0] ctr;
    int k;
    for (int n = 0; n < count; n++) begin
      t.last = ($urandom_range(7) == 0);
      if ($urandom_range(99) < 70) begin
        k = $urandom_range(0, 5);
        for (int i = 0; i < 3; i++) begin
          ctr = 64'(sb.org[i]) + 64'(sb.dir[i]) * k;
          for (int j = 0; j < 3; j++)
            t.v[3*j+i] = ctr[CW-1:0] + $signed($urandom_range(0, 6*ONE)) - 3*ONE;
        end
      end else begin
        foreach (t.v[i]) t.v[i] = $urandom;
      end
      send_tri(t);
    end
  endtask

  initial begin
    logic signed [CW-1:0] o [3], d [3];
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset ray has zero direction: every triangle is flat against it
    send_coords(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, 0, 0, 0, 1'b0);
    send_coords(CMIN, CMAX, 0, CMAX, 0, CMIN, 0, CMIN, CMAX, 1'b1);
    send_coords(-ONE, -ONE, 0, ONE, -ONE, 0, -ONE, ONE, 0, 1'b0);
    random_mesh(40);
    wait_idle();

    // ray down the z axis from z = -10
    load_ray(0, 0, -10*ONE, 0, 0, ONE, 32'hABCD_0001);
    send_coords(-ONE, -ONE, 0, ONE, -ONE, 0, -ONE, ONE, 0, 1'b0);      // on edge
    send_coords(-ONE, -ONE, 0, -ONE, ONE, 0, ONE, -ONE, 0, 1'b0);      // reversed
    send_coords(-ONE, -ONE, 0, 3*ONE, -ONE, 0, -ONE, 3*ONE, 0, 1'b0);  // inside
    send_coords(2*ONE, 2*ONE, 0, 4*ONE, 2*ONE, 0, 2*ONE, 4*ONE, 0, 1'b0); // off
    send_coords(-ONE, -ONE, -20*ONE, 3*ONE, -ONE, -20*ONE, -ONE, 3*ONE,
                -20*ONE, 1'b0);                                        // behind
    send_coords(-ONE, -ONE, -10*ONE, 3*ONE, -ONE, -10*ONE, -ONE, 3*ONE,
                -10*ONE, 1'b0);                                        // t = 0
    send_coords(-ONE, -ONE, -10*ONE+1, 3*ONE, -ONE, -10*ONE+1, -ONE, 3*ONE,
                -10*ONE+1, 1'b0);                                      // t = eps
    send_coords(-ONE, -ONE, -10*ONE+2, 3*ONE, -ONE, -10*ONE+2, -ONE, 3*ONE,
                -10*ONE+2, 1'b0);                                      // just past
    send_coords(0, 0, 0, ONE, 0, 0, 0, 0, ONE, 1'b0);                  // parallel
    send_coords(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, 1'b0);    // point
    send_coords(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, 1'b0);
    send_coords(CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, 1'b1);
    random_mesh(200);
    wait_idle();

    // assorted rays, tolerance extremes, one stretch without gaps
    for (int ph = 0; ph < 7; ph++) begin
      foreach (o[i]) begin
        o[i] = $signed($urandom_range(0, 10*ONE)) - 5*ONE;
        d[i] = $signed($urandom_range(0, 4*ONE)) - 2*ONE;
      end
      if (ph == 5) begin
        o = '{CMAX - ONE, CMIN + ONE, CMAX};
        d = '{CMAX, CMIN, ONE};
      end
      if (ph == 6) d = '{CMIN, CMAX, CMIN};
      load_ray(o[0], o[1], o[2], d[0], d[1], d[2],
               ph == 0 ? 32'h0 : ph == 1 ? 32'hFFFF_FFFF : $urandom);
      no_gaps = (ph == 3);
      random_mesh(250);
      wait_idle();
    end

    if (sb.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/rti_pkg.sv
rtl/core/rti_mul.sv
rtl/core/rti_front.sv
rtl/core/rti_fifo.sv
rtl/core/rti_back.sv
rtl/core/ray_triangle_intersect.sv
test/tb_ray_triangle_intersect.sv
